// ===== hw/rtl/pcl_pkg.sv =====
package pcl_pkg;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int SLOT_W    = 5;
  localparam int CHAN_W    = 8;
  localparam int COORD_W   = 12;
  localparam int KIND_W    = 2;
  localparam int LABEL_W   = 5;
  localparam int SUM_W     = 32;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int COLOR_W   = 3 * CHAN_W;

  // sizes and limits
  localparam int PAL_SIZE_DEF     = 32;
  localparam int LAYER_SLOTS      = 32;
  localparam int MAX_DIM          = 4096;
  localparam int MIN_LAYER_WEIGHT = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_PAL_WR    = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL     = 2'd1;
  localparam logic [OP_W-1:0] OP_FRAME_END = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LAYER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THR = 2'd1;

  // register reset values
  localparam logic [COUNT_W-1:0] PAL_COUNT_RST = 6'd1;
  localparam logic [CHAN_W-1:0]  ALPHA_THR_RST = 8'd24;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [SLOT_W-1:0]  entry_index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LABEL_W-1:0] label;
    logic               visible;
    logic [COORD_W-1:0] min_col;
    logic [COORD_W-1:0] min_row;
    logic [COORD_W-1:0] max_col;
    logic [COORD_W-1:0] max_row;
    logic [SUM_W-1:0]   alpha_sum;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] value;
  } cfg_item_t;

  // one layer's statistics as held in the layer store
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [SUM_W-1:0]   weight;
  } layer_stat_t;

endpackage

// ===== hw/rtl/pcl_stream_if.sv =====
interface pcl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pcl_ram.sv =====
module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/palette_classify_layer_bounds.sv =====
// channel   role    beat payload
// in_chan   sink    operation, entry_index, red, green, blue, alpha, pixel_x, pixel_y
// out_chan  source  kind, label, visible, min_col..max_row, alpha_sum, last
// cfg_chan  sink    index, value (0 palette_count, 1 alpha_threshold)
//
// palette write: stored as the beat is taken; invisible pixel: one result beat
// visible pixel: the n palette entries in use are scanned, then the layer is updated;
//   one shared distance unit compares one palette entry per cycle
// end of frame: a record per live layer slot, or an empty beat if none is live;
//   slots are visited in order, and a live slot's stats are read in its scan cycle
// rst_n is synchronous; input is taken only in idle, a stalled output holds
//   the block in its last step; config is always ready
module palette_classify_layer_bounds #(
  parameter int PALETTE_SIZE = pcl_pkg::PAL_SIZE_DEF
) (
  input logic          clk,
  input logic          rst_n,
  pcl_stream_if.sink   in_chan,
  pcl_stream_if.source out_chan,
  pcl_stream_if.sink   cfg_chan
);

  import pcl_pkg::*;

  localparam int PAW        = $clog2(PALETTE_SIZE);
  localparam int LAW        = $clog2(LAYER_SLOTS);
  localparam int SCAN_LIMIT = (PALETTE_SIZE < LAYER_SLOTS) ? PALETTE_SIZE : LAYER_SLOTS;
  localparam int SQ_W       = 2 * CHAN_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int LW         = $bits(layer_stat_t);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_LREAD   = 8'b0000_0100,
    S_LUPD    = 8'b0000_1000,
    S_PIX_OUT = 8'b0001_0000,
    S_FREAD   = 8'b0010_0000,
    S_FEMIT   = 8'b0100_0000,
    S_EMPTY   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [COUNT_W-1:0] pal_count_r;
  logic [CHAN_W-1:0]  alpha_thr_r;

  // latched pixel
  logic [CHAN_W-1:0]  pix_red_r, pix_green_r, pix_blue_r, pix_alpha_r;
  logic [COORD_W-1:0] pix_x_r, pix_y_r;
  logic [COORD_W-1:0] x_clamp, y_clamp;

  // distance scan
  logic [COUNT_W-1:0] rd_idx_r, n_r, n_eff;
  logic               v1_r, v2_r;
  logic [LAW-1:0]     idx1_r, idx2_r;
  logic [SQ_W-1:0]    sq_red_r, sq_green_r, sq_blue_r;
  logic [CHAN_W-1:0]  diff_red, diff_green, diff_blue;
  logic [DIST_W-1:0]  cand_d, best_d_r;
  logic [LAW-1:0]     best_r;
  logic               scan_issue, scan_done, take_best;

  // palette store
  logic               pal_we;
  logic [PAW-1:0]     pal_waddr, pal_raddr;
  logic [COLOR_W-1:0] pal_wdata, pal_rdata;

  // layer store and flags
  logic [LAYER_SLOTS-1:0] layer_seen_r, layer_live_r;
  logic [LAW-1:0]         frame_idx_r;
  logic                   lay_we;
  logic [LAW-1:0]         lay_raddr;
  logic [LW-1:0]          lay_rdata;
  layer_stat_t            lay_cur, lay_new;
  logic [SUM_W:0]         wsum;
  logic                   seen_best;

  // handshake strobes
  logic in_ready, in_fire, out_free;
  logic pix_vis, upd_fire, inv_fire, fe_emit, fe_last, empty_fire, frame_clear;

  // output register
  out_item_t out_r, out_d;
  logic      out_valid_r, out_load;

  assign in_ready      = (state_r == S_IDLE);
  assign in_chan.ready = in_ready;
  assign in_fire       = in_chan.valid && in_ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;

  assign pix_vis = (in_chan.data.alpha >= alpha_thr_r);

  // coordinate clamp to the image size
  assign x_clamp = (32'(in_chan.data.pixel_x) > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1)
                                                             : in_chan.data.pixel_x;
  assign y_clamp = (32'(in_chan.data.pixel_y) > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1)
                                                             : in_chan.data.pixel_y;

  // entries in use: zero acts as one, capped at the smaller of palette size and layer slots
  always_comb begin
    if (pal_count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (32'(pal_count_r) > SCAN_LIMIT) begin
      n_eff = COUNT_W'(SCAN_LIMIT);
    end else begin
      n_eff = pal_count_r;
    end
  end

  // palette store access
  assign pal_we    = in_fire && (in_chan.data.operation == OP_PAL_WR) &&
                     (32'(in_chan.data.entry_index) < PALETTE_SIZE);
  assign pal_waddr = PAW'(in_chan.data.entry_index);
  assign pal_wdata = {in_chan.data.red, in_chan.data.green, in_chan.data.blue};
  assign pal_raddr = PAW'(rd_idx_r);

  pcl_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_SIZE)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  // shared distance unit: squares, then sum and compare
  assign diff_red   = (pix_red_r > pal_rdata[23:16]) ? pix_red_r - pal_rdata[23:16]
                                                     : pal_rdata[23:16] - pix_red_r;
  assign diff_green = (pix_green_r > pal_rdata[15:8]) ? pix_green_r - pal_rdata[15:8]
                                                      : pal_rdata[15:8] - pix_green_r;
  assign diff_blue  = (pix_blue_r > pal_rdata[7:0]) ? pix_blue_r - pal_rdata[7:0]
                                                    : pal_rdata[7:0] - pix_blue_r;
  assign cand_d     = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);

  assign scan_issue = (state_r == S_SCAN) && (rd_idx_r < n_r);
  assign take_best  = v2_r && ((idx2_r == '0) || (cand_d < best_d_r));
  assign scan_done  = v2_r && (COUNT_W'(idx2_r) == n_r - COUNT_W'(1));

  // layer store access
  assign lay_raddr = ((state_r == S_FREAD) || (state_r == S_FEMIT)) ? frame_idx_r : best_r;
  assign lay_cur   = lay_rdata;
  assign seen_best = layer_seen_r[best_r];

  pcl_ram #(
    .WIDTH (LW),
    .DEPTH (LAYER_SLOTS)
  ) u_layer_ram (
    .clk   (clk),
    .we    (lay_we),
    .waddr (best_r),
    .wdata (lay_new),
    .raddr (lay_raddr),
    .rdata (lay_rdata)
  );

  // bounding box widen and saturating alpha sum
  always_comb begin
    if (!seen_best) begin
      lay_new.left   = pix_x_r;
      lay_new.right  = pix_x_r;
      lay_new.top    = pix_y_r;
      lay_new.bottom = pix_y_r;
      wsum           = (SUM_W + 1)'(pix_alpha_r);
    end else begin
      lay_new.left   = (pix_x_r < lay_cur.left)   ? pix_x_r : lay_cur.left;
      lay_new.right  = (pix_x_r > lay_cur.right)  ? pix_x_r : lay_cur.right;
      lay_new.top    = (pix_y_r < lay_cur.top)    ? pix_y_r : lay_cur.top;
      lay_new.bottom = (pix_y_r > lay_cur.bottom) ? pix_y_r : lay_cur.bottom;
      wsum           = {1'b0, lay_cur.weight} + (SUM_W + 1)'(pix_alpha_r);
    end
    lay_new.weight = wsum[SUM_W] ? '1 : wsum[SUM_W-1:0];
  end

  assign upd_fire    = (state_r == S_LUPD) && out_free;
  assign lay_we      = upd_fire;
  assign inv_fire    = (state_r == S_PIX_OUT) && out_free;
  assign fe_emit     = (state_r == S_FEMIT) && out_free;
  assign empty_fire  = (state_r == S_EMPTY) && out_free;
  assign fe_last     = ((layer_live_r >> frame_idx_r) >> 1) == '0;
  assign frame_clear = (fe_emit && fe_last) || empty_fire;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.data.operation)
            OP_PIXEL:     state_nxt = pix_vis ? S_SCAN : S_PIX_OUT;
            OP_FRAME_END: state_nxt = (layer_live_r == '0) ? S_EMPTY : S_FREAD;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN:    if (scan_done) state_nxt = S_LREAD;
      S_LREAD:   state_nxt = S_LUPD;
      S_LUPD:    if (upd_fire) state_nxt = S_IDLE;
      S_PIX_OUT: if (inv_fire) state_nxt = S_IDLE;
      S_FREAD:   if (layer_live_r[frame_idx_r]) state_nxt = S_FEMIT;
      S_FEMIT:   if (fe_emit) state_nxt = fe_last ? S_IDLE : S_FREAD;
      S_EMPTY:   if (empty_fire) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // result beat assembly
  always_comb begin
    out_d    = '0;
    out_load = upd_fire || inv_fire || fe_emit || empty_fire;
    if (upd_fire) begin
      out_d.kind    = KIND_PIXEL;
      out_d.label   = best_r;
      out_d.visible = 1'b1;
      out_d.last    = 1'b1;
    end else if (inv_fire) begin
      out_d.kind = KIND_PIXEL;
      out_d.last = 1'b1;
    end else if (fe_emit) begin
      out_d.kind      = KIND_LAYER;
      out_d.label     = frame_idx_r;
      out_d.visible   = 1'b1;
      out_d.min_col   = lay_cur.left;
      out_d.min_row   = lay_cur.top;
      out_d.max_col   = lay_cur.right;
      out_d.max_row   = lay_cur.bottom;
      out_d.alpha_sum = lay_cur.weight;
      out_d.last      = fe_last;
    end else if (empty_fire) begin
      out_d.kind = KIND_EMPTY;
      out_d.last = 1'b1;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pal_count_r  <= PAL_COUNT_RST;
      alpha_thr_r  <= ALPHA_THR_RST;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      layer_seen_r <= '0;
      layer_live_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= scan_issue;
      v2_r    <= v1_r;

      // config beat
      if (cfg_chan.valid) begin
        case (cfg_chan.data.index)
          CFG_PAL_COUNT: pal_count_r <= cfg_chan.data.value[COUNT_W-1:0];
          CFG_ALPHA_THR: alpha_thr_r <= cfg_chan.data.value;
          default:       ;
        endcase
      end

      // layer flags
      if (frame_clear) begin
        layer_seen_r <= '0;
        layer_live_r <= '0;
      end else if (upd_fire) begin
        layer_seen_r[best_r] <= 1'b1;
        layer_live_r[best_r] <= (32'(lay_new.weight) >= MIN_LAYER_WEIGHT);
      end

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    // pixel latch and scan start
    if (in_fire) begin
      pix_red_r   <= in_chan.data.red;
      pix_green_r <= in_chan.data.green;
      pix_blue_r  <= in_chan.data.blue;
      pix_alpha_r <= in_chan.data.alpha;
      pix_x_r     <= x_clamp;
      pix_y_r     <= y_clamp;
      rd_idx_r    <= '0;
      n_r         <= n_eff;
      frame_idx_r <= '0;
    end else begin
      if (scan_issue) begin
        rd_idx_r <= rd_idx_r + COUNT_W'(1);
      end
      if (((state_r == S_FREAD) && !layer_live_r[frame_idx_r]) || (fe_emit && !fe_last)) begin
        frame_idx_r <= frame_idx_r + LAW'(1);
      end
    end

    // distance pipeline
    idx1_r     <= rd_idx_r[LAW-1:0];
    idx2_r     <= idx1_r;
    sq_red_r   <= SQ_W'(diff_red) * SQ_W'(diff_red);
    sq_green_r <= SQ_W'(diff_green) * SQ_W'(diff_green);
    sq_blue_r  <= SQ_W'(diff_blue) * SQ_W'(diff_blue);
    if (take_best) begin
      best_d_r <= cand_d;
      best_r   <= idx2_r;
    end

    if (out_load) begin
      out_r <= out_d;
    end
  end

  // checks
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LREAD) |-> (COUNT_W'(best_r) < n_r))
    else $error("nearest entry index outside the entries in use");

  a_emit_live_layer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEMIT) |-> layer_live_r[frame_idx_r])
    else $error("layer record for a layer without weight");

  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> (!v1_r && !v2_r))
    else $error("distance pipeline busy outside the scan");

  a_scan_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.data.operation == OP_PIXEL) && pix_vis) |=>
      (rd_idx_r == '0) && (n_r != '0))
    else $error("scan started with bad count");

endmodule

// ===== tb/palette_classify_layer_bounds_test.sv =====
module palette_classify_layer_bounds_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pcl_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 80;
  localparam int IDLE_PCT      = 23;
  localparam int HOLD_AT_BEAT  = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 37;
  localparam int MAX_SHOWN     = 40;
  localparam longint LIMIT_NS  = 10_000_000;

  // per-phase register settings, negative means a random 8-bit value
  localparam int PH_COUNT [PHASES] = '{32, 1, -1, 63, -1, 2};
  localparam int PH_THR   [PHASES] = '{24, 0, -1, 255, -1, 128};

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [COORD_W-1:0]   COORD_MAX  = COORD_W'(MAX_DIM - 1);

  typedef enum {ROW_ITEM, ROW_CFG, ROW_FILL} row_kind_t;

  typedef struct {
    row_kind_t            what;
    in_item_t             item;
    bit                   typed;
    out_item_t            want;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DAT_W-1:0] reg_val;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   errors;

  // result beats still owed by the block, oldest first
  out_item_t owed [$];

  // predictor copy of palette, layer stores and registers
  logic [COLOR_W-1:0] pal_rgb    [PAL_SIZE_DEF];
  bit                 pal_loaded [PAL_SIZE_DEF];
  bit                 lyr_seen   [LAYER_SLOTS];
  logic [COORD_W-1:0] lyr_left   [LAYER_SLOTS];
  logic [COORD_W-1:0] lyr_top    [LAYER_SLOTS];
  logic [COORD_W-1:0] lyr_right  [LAYER_SLOTS];
  logic [COORD_W-1:0] lyr_bottom [LAYER_SLOTS];
  logic [SUM_W-1:0]   lyr_weight [LAYER_SLOTS];
  logic [COUNT_W-1:0] pal_in_use;
  logic [CHAN_W-1:0]  alpha_floor;

  pcl_stream_if #(.T(in_item_t))  in_chan ();
  pcl_stream_if #(.T(out_item_t)) out_chan ();
  pcl_stream_if #(.T(cfg_item_t)) cfg_chan ();

  palette_classify_layer_bounds i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // mismatch report, one line each for the first MAX_SHOWN
  task automatic note_error(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= MAX_SHOWN) begin
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  function automatic out_item_t beat(logic [KIND_W-1:0] k, logic [LABEL_W-1:0] lbl,
                                     logic vis, logic [COORD_W-1:0] c0,
                                     logic [COORD_W-1:0] r0, logic [COORD_W-1:0] c1,
                                     logic [COORD_W-1:0] r1, logic [SUM_W-1:0] sum,
                                     logic lst);
    out_item_t o;
    o.kind      = k;
    o.label     = lbl;
    o.visible   = vis;
    o.min_col   = c0;
    o.min_row   = r0;
    o.max_col   = c1;
    o.max_row   = r1;
    o.alpha_sum = sum;
    o.last      = lst;
    return o;
  endfunction

  function automatic void clear_layers();
    for (int i = 0; i < LAYER_SLOTS; i++) begin
      lyr_seen[i]   = 1'b0;
      lyr_left[i]   = '0;
      lyr_top[i]    = '0;
      lyr_right[i]  = '0;
      lyr_bottom[i] = '0;
      lyr_weight[i] = '0;
    end
  endfunction

  // zero acts as one, large counts saturate at the slot count
  function automatic int entries_in_use();
    if (pal_in_use == 0) return 1;
    if (pal_in_use > PAL_SIZE_DEF) return PAL_SIZE_DEF;
    return int'(pal_in_use);
  endfunction

  function automatic int sqd(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // expected beats for one accepted item, with state update
  function automatic void classify_or_flush(input in_item_t it, output out_item_t res [$]);
    int n;
    int best;
    int bestd;
    int d;
    logic [SUM_W:0] sum;
    res.delete();
    case (it.operation)
      OP_PAL_WR: begin
        pal_rgb[it.entry_index]    = {it.red, it.green, it.blue};
        pal_loaded[it.entry_index] = 1'b1;
      end
      OP_PIXEL: begin
        if (it.alpha < alpha_floor) begin
          res.push_back(beat(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          n     = entries_in_use();
          best  = 0;
          bestd = 0;
          // nearest entry, strict compare keeps the lower index on a tie
          for (int i = 0; i < n; i++) begin
            d = sqd(it.red, pal_rgb[i][2*CHAN_W +: CHAN_W])
              + sqd(it.green, pal_rgb[i][CHAN_W +: CHAN_W])
              + sqd(it.blue, pal_rgb[i][0 +: CHAN_W]);
            if (i == 0 || d < bestd) begin
              bestd = d;
              best  = i;
            end
          end
          // widen the bounding box
          if (!lyr_seen[best]) begin
            lyr_seen[best]   = 1'b1;
            lyr_left[best]   = it.pixel_x;
            lyr_right[best]  = it.pixel_x;
            lyr_top[best]    = it.pixel_y;
            lyr_bottom[best] = it.pixel_y;
          end else begin
            if (it.pixel_x < lyr_left[best])   lyr_left[best]   = it.pixel_x;
            if (it.pixel_x > lyr_right[best])  lyr_right[best]  = it.pixel_x;
            if (it.pixel_y < lyr_top[best])    lyr_top[best]    = it.pixel_y;
            if (it.pixel_y > lyr_bottom[best]) lyr_bottom[best] = it.pixel_y;
          end
          // saturating alpha sum
          sum = lyr_weight[best] + it.alpha;
          lyr_weight[best] = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
          res.push_back(beat(KIND_PIXEL, LABEL_W'(best), 1, 0, 0, 0, 0, 0, 1));
        end
      end
      OP_FRAME_END: begin
        for (int i = 0; i < LAYER_SLOTS; i++) begin
          if (lyr_seen[i] && lyr_weight[i] >= MIN_LAYER_WEIGHT) begin
            res.push_back(beat(KIND_LAYER, LABEL_W'(i), 1, lyr_left[i], lyr_top[i],
                               lyr_right[i], lyr_bottom[i], lyr_weight[i], 0));
          end
        end
        if (res.size() == 0) begin
          res.push_back(beat(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0));
        end
        res[res.size()-1].last = 1'b1;
        clear_layers();
      end
      default: ;
    endcase
  endfunction

  // item builders for the directed table
  function automatic in_item_t pix(logic [COLOR_W-1:0] rgb, logic [CHAN_W-1:0] a,
                                   logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    in_item_t it;
    it = '0;
    it.operation = OP_PIXEL;
    {it.red, it.green, it.blue} = rgb;
    it.alpha   = a;
    it.pixel_x = x;
    it.pixel_y = y;
    return it;
  endfunction

  function automatic in_item_t pal_wr(logic [SLOT_W-1:0] slot, logic [COLOR_W-1:0] rgb);
    in_item_t it;
    it = '0;
    it.operation   = OP_PAL_WR;
    it.entry_index = slot;
    {it.red, it.green, it.blue} = rgb;
    return it;
  endfunction

  function automatic row_t step_row(in_item_t it);
    row_t r;
    r.what    = ROW_ITEM;
    r.item    = it;
    r.typed   = 1'b0;
    r.want    = '0;
    r.reg_idx = '0;
    r.reg_val = '0;
    return r;
  endfunction

  function automatic row_t known_row(in_item_t it, out_item_t want);
    row_t r;
    r       = step_row(it);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    row_t r;
    r         = step_row('0);
    r.what    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // random stimulus helpers
  function automatic logic [CHAN_W-1:0] clamp_chan(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return CHAN_W'(v);
  endfunction

  function automatic logic [CHAN_W-1:0] jitter(logic [CHAN_W-1:0] c, int spread);
    return clamp_chan(int'(c) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(19))
      0, 1, 2: return '0;
      3, 4, 5: return COORD_MAX;
      default: return COORD_W'($urandom_range(COORD_MAX));
    endcase
  endfunction

  // mostly pixels near palette colors, some loads, frame ends and noise
  function automatic in_item_t gen_item();
    in_item_t it;
    int roll;
    int j;
    it   = $bits(in_item_t)'({$urandom, $urandom});
    roll = $urandom_range(99);
    if (roll < 6) begin
      it.operation = OP_PAL_WR;
      if (roll < 3) begin
        {it.red, it.green, it.blue} = pal_rgb[$urandom_range(PAL_SIZE_DEF - 1)];
      end
    end else if (roll < 14) begin
      it.operation = OP_FRAME_END;
    end else if (roll < 16) begin
      it.operation = OP_UNUSED;
    end else begin
      it.operation = OP_PIXEL;
      j = $urandom_range(entries_in_use() - 1);
      case ($urandom_range(9))
        0, 1: {it.red, it.green, it.blue} = pal_rgb[j];
        2, 3, 4, 5, 6: begin
          it.red   = jitter(pal_rgb[j][2*CHAN_W +: CHAN_W], 12);
          it.green = jitter(pal_rgb[j][CHAN_W +: CHAN_W], 12);
          it.blue  = jitter(pal_rgb[j][0 +: CHAN_W], 12);
        end
        default: ;
      endcase
      case ($urandom_range(9))
        0, 1, 2: it.alpha = clamp_chan(int'(alpha_floor) + int'($urandom_range(2)) - 1);
        3: it.alpha = '1;
        4: it.alpha = '0;
        default: ;
      endcase
      it.pixel_x = pick_coord();
      it.pixel_y = pick_coord();
    end
    return it;
  endfunction

  // offer one input beat, predict once it is taken
  task automatic offer_item(in_item_t it, bit typed, out_item_t want);
    out_item_t res [$];
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    classify_or_flush(it, res);
    if (typed) begin
      owed.push_back(want);
    end else begin
      foreach (res[i]) owed.push_back(res[i]);
    end
  endtask

  // stop offering until the block has delivered everything and gone quiet
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    settle();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= cfg_item_t'{index: idx, value: val};
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    cfg_chan.valid <= 1'b0;
    case (idx)
      CFG_PAL_COUNT: pal_in_use = val[COUNT_W-1:0];
      CFG_ALPHA_THR: alpha_floor = val;
      default: ;
    endcase
  endtask

  task automatic check_beat(out_item_t got, out_item_t want);
    if (got.kind !== want.kind)           note_error("kind", got.kind, want.kind);
    if (got.label !== want.label)         note_error("label", got.label, want.label);
    if (got.visible !== want.visible)     note_error("visible", got.visible, want.visible);
    if (got.min_col !== want.min_col)     note_error("min_col", got.min_col, want.min_col);
    if (got.min_row !== want.min_row)     note_error("min_row", got.min_row, want.min_row);
    if (got.max_col !== want.max_col)     note_error("max_col", got.max_col, want.max_col);
    if (got.max_row !== want.max_row)     note_error("max_row", got.max_row, want.max_row);
    if (got.alpha_sum !== want.alpha_sum) note_error("alpha_sum", got.alpha_sum, want.alpha_sum);
    if (got.last !== want.last)           note_error("last", got.last, want.last);
  endtask

  // result side: check every beat, random stalls plus one long hold-off
  initial begin
    int seen;
    int hold_left;
    bit held;
    seen      = 0;
    hold_left = 0;
    held      = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        seen++;
        if (owed.size() == 0) begin
          note_error("result beat with nothing owed, kind", out_chan.data.kind, 0);
        end else begin
          check_beat(out_chan.data, owed.pop_front());
        end
      end
      if (!held && seen == HOLD_AT_BEAT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // stimulus: directed table, then random phases
  initial begin
    row_t      plan [$];
    row_t      fill;
    in_item_t  eof_it;
    in_item_t  it;
    out_item_t hidden;
    out_item_t lbl0;
    out_item_t empty_rec;
    int        counted;

    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data  <= '0;
    steady      = 1'b0;
    errors      = 0;
    pal_in_use  = PAL_COUNT_RST;
    alpha_floor = ALPHA_THR_RST;
    clear_layers();

    eof_it = '0;
    eof_it.operation = OP_FRAME_END;
    hidden    = beat(KIND_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1);
    lbl0      = beat(KIND_PIXEL, 0, 1, 0, 0, 0, 0, 0, 1);
    empty_rec = beat(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0, 1);
    fill      = step_row('0);
    fill.what = ROW_FILL;

    // reset settings: one entry in use, threshold 24
    plan.push_back(known_row(eof_it, empty_rec));
    plan.push_back(known_row(pix(24'hFFFFFF, 8'd23, COORD_MAX, COORD_MAX), hidden));
    plan.push_back(known_row(pix(24'h000000, 8'd0, 0, 0), hidden));
    plan.push_back(step_row(in_item_t'('1)));
    plan.push_back(step_row(pal_wr(0, 24'h000000)));
    plan.push_back(known_row(pix(24'hFFFFFF, 8'd24, 0, COORD_MAX), lbl0));
    plan.push_back(known_row(pix(24'h808080, 8'd255, COORD_MAX, 0), lbl0));
    plan.push_back(known_row(eof_it,
                             beat(KIND_LAYER, 0, 1, 0, 0, COORD_MAX, COORD_MAX, 279, 1)));
    // threshold zero: a zero-alpha pixel labels a layer that stays weightless
    plan.push_back(reg_row(CFG_ALPHA_THR, 8'd0));
    plan.push_back(known_row(pix(24'h123456, 8'd0, 5, 6), lbl0));
    plan.push_back(known_row(eof_it, empty_rec));
    // count zero acts as one, top threshold, write to a missing register
    plan.push_back(reg_row(CFG_PAL_COUNT, 8'd0));
    plan.push_back(reg_row(CFG_ALPHA_THR, 8'd255));
    plan.push_back(reg_row(CFG_NO_REG, 8'hFF));
    plan.push_back(known_row(pix(24'hFFFFFF, 8'd254, 1, 1), hidden));
    plan.push_back(known_row(pix(24'hFFFFFF, 8'd255, 9, 3), lbl0));
    // full palette, duplicates for ties, count above the slot count
    plan.push_back(step_row(pal_wr(31, 24'hFFFFFF)));
    plan.push_back(step_row(pal_wr(1, 24'h000000)));
    plan.push_back(fill);
    plan.push_back(reg_row(CFG_PAL_COUNT, 8'd63));
    plan.push_back(reg_row(CFG_ALPHA_THR, ALPHA_THR_RST));
    plan.push_back(step_row(pal_wr(3, 24'h404040)));
    plan.push_back(step_row(pal_wr(9, 24'h404040)));
    plan.push_back(step_row(pix(24'h404040, 8'd128, 100, 200)));
    plan.push_back(known_row(pix(24'h000000, 8'd255, 0, 0), lbl0));
    plan.push_back(step_row(pix(24'hFFFFFF, 8'd200, COORD_MAX, 2)));
    plan.push_back(step_row(eof_it));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      case (plan[k].what)
        ROW_ITEM: offer_item(plan[k].item, plan[k].typed, plan[k].want);
        ROW_CFG:  write_reg(plan[k].reg_idx, plan[k].reg_val);
        ROW_FILL: begin
          for (int s = 0; s < PAL_SIZE_DEF; s++) begin
            if (!pal_loaded[s]) offer_item(pal_wr(SLOT_W'(s), COLOR_W'($urandom)), 0, '0);
          end
        end
        default: ;
      endcase
    end

    // random phases, each after a full drain and new settings
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_PAL_COUNT, PH_COUNT[ph] < 0 ? CFG_DAT_W'($urandom)
                                                : CFG_DAT_W'(PH_COUNT[ph]));
      write_reg(CFG_ALPHA_THR, PH_THR[ph] < 0 ? CFG_DAT_W'($urandom)
                                              : CFG_DAT_W'(PH_THR[ph]));
      steady  = (ph == 2);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = gen_item();
        if (it.operation != OP_UNUSED) counted++;
        offer_item(it, 0, '0);
      end
    end
    steady = 1'b0;

    in_chan.valid <= 1'b0;
    while (owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("palette_classify_layer_bounds_test: clean");
    end else begin
      $display("palette_classify_layer_bounds_test: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("palette_classify_layer_bounds_test: errors");
    $finish;
  end

endmodule

// ===== palette_classify_layer_bounds.f =====
hw/rtl/pcl_pkg.sv
hw/rtl/pcl_stream_if.sv
hw/rtl/pcl_ram.sv
hw/rtl/palette_classify_layer_bounds.sv
tb/palette_classify_layer_bounds_test.sv
